[hdl/scsa_pkg.sv]
// Shared types and constants for the size-class slab allocator.
`timescale 1ns / 1ps
`default_nettype none
package scsa_pkg;

  localparam int NUM_CLASSES = 10;
  localparam int PAGE_SHIFT  = 12;
  localparam int BLK_BITS    = 9;
  localparam int ADDR_W      = 18;

  localparam logic [9:0]  STACK_EMPTY = 10'd512;
  localparam logic [3:0]  NO_CLASS    = 4'd15;
  localparam logic [15:0] MAX_SIZE    = 16'd4096;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_PAGES = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_size;
    logic [17:0] block_address;
  } in_t;

  typedef struct packed {
    logic [17:0] address;
    logic [1:0]  status;
  } out_t;

  // Per-page record held in the page memory.
  typedef struct packed {
    logic [3:0] cls;
    logic [9:0] head;
    logic [9:0] fresh;
  } page_meta_t;

  // Update of one page's room flag in the search map.
  typedef struct packed {
    logic       we;
    logic [3:0] cls;
    logic       room;
  } room_upd_t;

endpackage
`default_nettype wire

[hdl/scsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/scsa_room_map.sv]
// Per-class room flags for every page and the lowest-page search over them.
`timescale 1ns / 1ps
`default_nettype none
module scsa_room_map #(
  parameter int NUM_PAGES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire scsa_pkg::room_upd_t          upd,
  input  wire logic [$clog2(NUM_PAGES)-1:0] upd_pg,
  input  wire logic [3:0]                   query_cls,
  output logic                              hit,
  output logic      [$clog2(NUM_PAGES)-1:0] hit_pg
);

  localparam int PW = $clog2(NUM_PAGES);

  logic [NUM_PAGES-1:0] avail [scsa_pkg::NUM_CLASSES];
  logic [NUM_PAGES-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
        avail[c]    <= '0;
        avail[c][c] <= 1'b1;
      end
    end else if (upd.we && (upd.cls < 4'(scsa_pkg::NUM_CLASSES))) begin
      avail[upd.cls][upd_pg] <= upd.room;
    end
  end

  always_comb begin
    sel    = (query_cls < 4'(scsa_pkg::NUM_CLASSES)) ? avail[query_cls] : '0;
    hit    = 1'b0;
    hit_pg = '0;
    // lowest set bit wins
    for (int i = NUM_PAGES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        hit    = 1'b1;
        hit_pg = PW'(i);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/size_class_slab_allocator.sv]
// Top level of the power-of-two size-class slab allocator.
`timescale 1ns / 1ps
`default_nettype none
// Hands out and takes back blocks of 8 to 4096 bytes carved from 4 KiB pages.
// One request beat yields exactly one result beat. After reset the block
// sweeps every entry of the page memory to its initial contents (in_ready
// low), then serves one request at a time. A bad size, a full pool, a free
// outside the pool and an allocation that opens a new page finish from
// S_DECODE. An allocation from a page with no freed block finishes from
// S_META, and any other free from S_FREE. An allocation that pops a freed
// block passes S_META and then S_LINK, since it reads the page memory and
// then the block link memory, each with registered read data. A result
// waiting in the output register holds the finishing step, and with it every
// memory write, until the slot is free. Page selection is a priority search
// over per-class room flags kept in flip-flops; each page's class, freed-stack
// head and count of fresh blocks live in the page memory, and the links of
// each freed stack live in the block link memory (NUM_PAGES * 512 entries,
// never cleared; an entry is only read after a free has written it). Frees of
// a block that was never handed out, or freed twice, are not caught.
module size_class_slab_allocator #(
  parameter int NUM_PAGES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire scsa_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output scsa_pkg::out_t      out_data
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = PW + scsa_pkg::BLK_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_META,
    S_LINK,
    S_FREE
  } state_t;

  state_t                 state;
  scsa_pkg::in_t          req;
  logic [PW-1:0]          pg_q;
  logic [3:0]             cls_q;
  logic [PW:0]            next_pg;
  logic [PW-1:0]          clr_idx;

  // page memory
  logic                   meta_we;
  logic [PW-1:0]          meta_waddr;
  scsa_pkg::page_meta_t   meta_wdata;
  logic [PW-1:0]          meta_raddr;
  scsa_pkg::page_meta_t   meta_rd;

  // block link memory
  logic                   link_we;
  logic [LW-1:0]          link_waddr;
  logic [9:0]             link_wdata;
  logic [LW-1:0]          link_raddr;
  logic [9:0]             link_rd;

  scsa_pkg::room_upd_t    room_upd;
  logic                   hit;
  logic [PW-1:0]          hit_pg;

  logic                   out_free;
  logic [3:0]             req_cls;
  logic                   size_bad;
  logic [5:0]             free_pg6;
  logic                   free_pg_ok;
  logic [11:0]            free_off;
  logic [12:0]            align_mask;
  logic                   free_bad;
  logic [9:0]             free_blk;
  logic [9:0]             blocks_req;
  logic [9:0]             blocks_meta;
  logic [9:0]             take_blk;
  logic [31:0]            pool_sum;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Round the size up to a power of two; smallest class whose block fits.
  always_comb begin
    req_cls = 4'd9;
    for (int c = scsa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if (req.request_size <= (16'd8 << c)) begin
        req_cls = 4'(c);
      end
    end
  end
  assign size_bad = (req.request_size == 16'd0) || (req.request_size > scsa_pkg::MAX_SIZE);

  assign free_pg6   = req.block_address[17:scsa_pkg::PAGE_SHIFT];
  assign free_pg_ok = (32'(free_pg6) < 32'(NUM_PAGES));
  assign free_off   = req.block_address[scsa_pkg::PAGE_SHIFT-1:0];
  assign align_mask = (13'd8 << meta_rd.cls) - 13'd1;
  assign free_bad   = (meta_rd.cls >= 4'(scsa_pkg::NUM_CLASSES)) ||
                      ((13'(free_off) & align_mask) != 13'd0);
  assign free_blk   = 10'(free_off >> (meta_rd.cls + 4'd3));

  assign blocks_req  = 10'(10'd512 >> cls_q);
  assign blocks_meta = blocks_req;
  assign take_blk    = (state == S_LINK) ? meta_rd.head : meta_rd.fresh;

  // Read the chosen page while deciding, then hold the page under work.
  // A free names its page directly; the search result only serves allocations.
  assign meta_raddr = (state == S_DECODE) ?
                      ((req.mode == scsa_pkg::MODE_FREE) ? PW'(free_pg6) : hit_pg) :
                      pg_q;
  assign link_raddr = {pg_q, meta_rd.head[scsa_pkg::BLK_BITS-1:0]};

  // Memory and room-map write ports.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = pg_q;
    meta_wdata = meta_rd;
    link_we    = 1'b0;
    link_waddr = {pg_q, free_blk[scsa_pkg::BLK_BITS-1:0]};
    link_wdata = meta_rd.head;
    room_upd   = '0;
    case (state)
      S_CLEAR: begin
        meta_we          = 1'b1;
        meta_waddr       = clr_idx;
        meta_wdata.cls   = (32'(clr_idx) < 32'(scsa_pkg::NUM_CLASSES)) ?
                           4'(clr_idx) : scsa_pkg::NO_CLASS;
        meta_wdata.head  = scsa_pkg::STACK_EMPTY;
        meta_wdata.fresh = 10'd0;
      end
      S_DECODE: begin
        // open a fresh page and take its first block at once
        if (req.mode == scsa_pkg::MODE_ALLOC && !size_bad && !hit &&
            next_pg < (PW+1)'(NUM_PAGES) && out_free) begin
          meta_we          = 1'b1;
          meta_waddr       = PW'(next_pg);
          meta_wdata.cls   = req_cls;
          meta_wdata.head  = scsa_pkg::STACK_EMPTY;
          meta_wdata.fresh = 10'd1;
          room_upd.we      = 1'b1;
          room_upd.cls     = req_cls;
          room_upd.room    = (10'd1 < 10'(10'd512 >> req_cls));
        end
      end
      S_META: begin
        if (meta_rd.head == scsa_pkg::STACK_EMPTY && out_free) begin
          meta_we          = 1'b1;
          meta_wdata.fresh = meta_rd.fresh + 10'd1;
          room_upd.we      = 1'b1;
          room_upd.cls     = cls_q;
          room_upd.room    = (meta_rd.fresh + 10'd1) < blocks_meta;
        end
      end
      S_LINK: begin
        if (out_free) begin
          meta_we         = 1'b1;
          meta_wdata.head = link_rd;
          room_upd.we     = 1'b1;
          room_upd.cls    = cls_q;
          room_upd.room   = (link_rd != scsa_pkg::STACK_EMPTY) ||
                            (meta_rd.fresh < blocks_meta);
        end
      end
      S_FREE: begin
        if (!free_bad && out_free) begin
          meta_we         = 1'b1;
          meta_wdata.head = free_blk;
          link_we         = 1'b1;
          room_upd.we     = 1'b1;
          room_upd.cls    = meta_rd.cls;
          room_upd.room   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign pool_sum = (32'(pg_q) << scsa_pkg::PAGE_SHIFT) +
                    (32'(take_blk) << (cls_q + 4'd3));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      next_pg   <= (PW+1)'(scsa_pkg::NUM_CLASSES);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + PW'(1);
          if (clr_idx == PW'(NUM_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cls_q <= req_cls;
          if (req.mode == scsa_pkg::MODE_FREE) begin
            if (free_pg_ok) begin
              pg_q  <= PW'(free_pg6);
              state <= S_FREE;
            end else if (out_free) begin
              out_valid <= 1'b1;
              out_data  <= '{address: '0, status: scsa_pkg::ST_BAD_FREE};
              state     <= S_IDLE;
            end
          end else if (!size_bad && hit) begin
            pg_q  <= hit_pg;
            state <= S_META;
          end else if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (size_bad) begin
              out_data <= '{address: '0, status: scsa_pkg::ST_BAD_SIZE};
            end else if (next_pg >= (PW+1)'(NUM_PAGES)) begin
              out_data <= '{address: '0, status: scsa_pkg::ST_NO_PAGES};
            end else begin
              // block 0 of the newly opened page
              out_data <= '{address: 18'(32'(next_pg) << scsa_pkg::PAGE_SHIFT),
                            status: scsa_pkg::ST_OK};
              next_pg  <= next_pg + (PW+1)'(1);
            end
          end
        end
        S_META: begin
          if (meta_rd.head != scsa_pkg::STACK_EMPTY) begin
            state <= S_LINK;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{address: pool_sum[scsa_pkg::ADDR_W-1:0], status: scsa_pkg::ST_OK};
            state     <= S_IDLE;
          end
        end
        S_LINK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{address: pool_sum[scsa_pkg::ADDR_W-1:0], status: scsa_pkg::ST_OK};
            state     <= S_IDLE;
          end
        end
        S_FREE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{address: '0,
                           status: free_bad ? scsa_pkg::ST_BAD_FREE : scsa_pkg::ST_OK};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  scsa_ram #(
    .WIDTH ($bits(scsa_pkg::page_meta_t)),
    .DEPTH (NUM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rd)
  );

  scsa_ram #(
    .WIDTH (10),
    .DEPTH (NUM_PAGES * 512)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  scsa_room_map #(
    .NUM_PAGES (NUM_PAGES)
  ) u_room_map (
    .clk       (clk),
    .rst       (rst),
    .upd       (room_upd),
    .upd_pg    ((state == S_DECODE) ? PW'(next_pg) : pg_q),
    .query_cls (req_cls),
    .hit       (hit),
    .hit_pg    (hit_pg)
  );

  // Any beat that is not ok carries address zero.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != scsa_pkg::ST_OK |-> out_data.address == '0)
    else $error("non-ok result with nonzero address");

  // Pages are only ever handed out, never returned to the unassigned pool.
  a_next_pg_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> next_pg >= $past(next_pg))
    else $error("next unassigned page went backwards");

  // Outside the reset sweep, page memory is written only when the result slot is free.
  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    meta_we && state != S_CLEAR |-> out_free)
    else $error("page write while result slot is full");

  // A link write always belongs to a free request.
  a_link_free: assert property (@(posedge clk) disable iff (rst)
    link_we |-> state == S_FREE && req.mode == scsa_pkg::MODE_FREE)
    else $error("link write outside a free");

endmodule
`default_nettype wire
